// ===== sv/cws_pkg.sv =====
package cws_pkg;

  // Screen and number format
  localparam int SCREEN_W   = 256;
  localparam int SCREEN_H   = 192;
  localparam int FRAC_BITS  = 12;
  localparam int MAX_RADIUS = 128;

  // Field widths
  localparam int CX_W   = 22;
  localparam int TY_W   = 21;
  localparam int R_W    = 20;
  localparam int ROW_W  = 8;
  localparam int ROWO_W = 8;
  localparam int COL_W  = 9;

  // Internal widths: positions, radicand (r*r <= 2^38), root
  localparam int POS_W  = 24;
  localparam int RAD_W  = 39;
  localparam int ROOT_W = (RAD_W + 1) / 2;
  localparam int TRL_W  = RAD_W + 2;

  // Pipeline depth, start transfer to result strobe
  localparam int PREP_LAT = 3;
  localparam int FIN_LAT  = 3;
  localparam int PIPE_LAT = PREP_LAT + ROOT_W + FIN_LAT;

  localparam logic signed [POS_W-1:0] SCR_W_FP = POS_W'(SCREEN_W * (1 << FRAC_BITS));
  localparam logic signed [POS_W-1:0] SCR_H_FP = POS_W'(SCREEN_H * (1 << FRAC_BITS));
  localparam logic [R_W-1:0]          MAX_R_FP = R_W'(MAX_RADIUS * (1 << FRAC_BITS));
  localparam logic signed [POS_W-1:0] ONE_M1   = POS_W'((1 << FRAC_BITS) - 1);

  // Per-item values carried alongside the square roots
  typedef struct packed {
    logic signed [POS_W-1:0] cx;
    logic signed [POS_W-1:0] ty;
    logic signed [POS_W-1:0] cr;    // top_y + r
    logic signed [POS_W-1:0] ty2r;  // top_y + 2r
    logic [ROW_W-1:0]        row;
    logic                    ext_mode;
  } cws_side_t;

  typedef struct packed {
    logic              vld;
    logic [RAD_W-1:0]  rad_ext;
    logic [RAD_W-1:0]  rad_row;
    cws_side_t         side;
  } cws_rad_t;

  typedef struct packed {
    logic              vld;
    logic [ROOT_W-1:0] h_ext;
    logic [ROOT_W-1:0] h_row;
    cws_side_t         side;
  } cws_root_t;

endpackage

// ===== sv/cws_prep.sv =====
module cws_prep (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_vld,
  input  logic signed [cws_pkg::CX_W-1:0]      in_cx,
  input  logic signed [cws_pkg::TY_W-1:0]      in_ty,
  input  logic [cws_pkg::R_W-1:0]              in_r,
  input  logic [cws_pkg::ROW_W-1:0]            in_row,
  output cws_pkg::cws_rad_t                    rad_o
);
  import cws_pkg::*;

  // stage 1: clamp radius, distances to the circle centre
  logic [R_W-1:0]          r_c;
  logic signed [POS_W-1:0] r_s, cx_e, ty_e, row_fp, de_full, dy, dy_abs;
  logic                    ext_neg, ext_pos;
  cws_side_t               side_nxt;
  logic                    de_ok_nxt, dr_ok_nxt;

  logic                    s1_vld_r;
  logic [R_W-1:0]          s1_r_r, s1_de_r, s1_dr_r;
  logic                    s1_de_ok_r, s1_dr_ok_r;
  cws_side_t               s1_side_r;

  // stage 2: squares
  logic [2*R_W-1:0]        rr_c, ee_c, yy_c;
  logic                    s2_vld_r;
  logic [RAD_W-1:0]        s2_rr_r, s2_ee_r, s2_yy_r;
  logic                    s2_de_ok_r, s2_dr_ok_r;
  cws_side_t               s2_side_r;

  // stage 3: radicands
  cws_rad_t                s3_r;
  cws_rad_t                s3_nxt;

  assign r_c    = (in_r > MAX_R_FP) ? MAX_R_FP : in_r;
  assign r_s    = signed'({{(POS_W-R_W){1'b0}}, r_c});
  assign cx_e   = POS_W'(in_cx);
  assign ty_e   = POS_W'(in_ty);
  assign row_fp = signed'({{(POS_W-ROW_W-FRAC_BITS){1'b0}}, in_row, {FRAC_BITS{1'b0}}});

  assign ext_neg = cx_e < 0;
  assign ext_pos = cx_e > SCR_W_FP;
  assign de_full = ext_neg ? -cx_e : cx_e - SCR_W_FP;

  always_comb begin
    side_nxt.cx       = cx_e;
    side_nxt.ty       = ty_e;
    side_nxt.cr       = ty_e + r_s;
    side_nxt.ty2r     = ty_e + (r_s <<< 1);
    side_nxt.row      = in_row;
    side_nxt.ext_mode = ext_neg | ext_pos;
  end

  assign dy        = row_fp - side_nxt.cr;
  assign dy_abs    = (dy < 0) ? -dy : dy;
  // a distance at or beyond the radius gives zero chord
  assign de_ok_nxt = (ext_neg | ext_pos) && (de_full < r_s);
  assign dr_ok_nxt = dy_abs < r_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_r.vld <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_r.vld <= s3_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_r_r     <= r_c;
    s1_de_r    <= de_full[R_W-1:0];
    s1_dr_r    <= dy_abs[R_W-1:0];
    s1_de_ok_r <= de_ok_nxt;
    s1_dr_ok_r <= dr_ok_nxt;
    s1_side_r  <= side_nxt;
  end

  assign rr_c = s1_r_r * s1_r_r;
  assign ee_c = s1_de_r * s1_de_r;
  assign yy_c = s1_dr_r * s1_dr_r;

  always_ff @(posedge clk) begin
    s2_rr_r    <= rr_c[RAD_W-1:0];
    s2_ee_r    <= ee_c[RAD_W-1:0];
    s2_yy_r    <= yy_c[RAD_W-1:0];
    s2_de_ok_r <= s1_de_ok_r;
    s2_dr_ok_r <= s1_dr_ok_r;
    s2_side_r  <= s1_side_r;
  end

  always_comb begin
    s3_nxt.vld     = s2_vld_r;
    s3_nxt.rad_ext = s2_de_ok_r ? s2_rr_r - s2_ee_r : '0;
    s3_nxt.rad_row = s2_dr_ok_r ? s2_rr_r - s2_yy_r : '0;
    s3_nxt.side    = s2_side_r;
  end

  always_ff @(posedge clk) begin
    s3_r.rad_ext <= s3_nxt.rad_ext;
    s3_r.rad_row <= s3_nxt.rad_row;
    s3_r.side    <= s3_nxt.side;
  end

  assign rad_o = s3_r;

endmodule

// ===== sv/cws_root_pipe.sv =====
module cws_root_pipe (
  input  logic               clk,
  input  logic               rst_n,
  input  cws_pkg::cws_rad_t  rad_i,
  output cws_pkg::cws_root_t root_o
);
  import cws_pkg::*;

  // one root bit per stage, both lanes side by side
  typedef struct packed {
    logic              vld;
    logic [RAD_W-1:0]  rem_e;
    logic [ROOT_W-1:0] q_e;
    logic [RAD_W-1:0]  rem_r;
    logic [ROOT_W-1:0] q_r;
    cws_side_t         side;
  } cws_rstage_t;

  cws_rstage_t st_r   [ROOT_W];
  cws_rstage_t st_nxt [ROOT_W];
  cws_rstage_t st_in  [ROOT_W];

  genvar i;
  generate
    for (i = 0; i < ROOT_W; i++) begin : g_stage
      localparam int K = ROOT_W - 1 - i;
      logic [TRL_W-1:0] trial_e, trial_r;

      if (i == 0) begin : g_first
        always_comb begin
          st_in[i].vld   = rad_i.vld;
          st_in[i].rem_e = rad_i.rad_ext;
          st_in[i].q_e   = '0;
          st_in[i].rem_r = rad_i.rad_row;
          st_in[i].q_r   = '0;
          st_in[i].side  = rad_i.side;
        end
      end else begin : g_next
        assign st_in[i] = st_r[i-1];
      end

      // (q + 2^K)^2 - q^2 = q*2^(K+1) + 4^K
      assign trial_e = (TRL_W'(st_in[i].q_e) << (K + 1)) | (TRL_W'(1) << (2 * K));
      assign trial_r = (TRL_W'(st_in[i].q_r) << (K + 1)) | (TRL_W'(1) << (2 * K));

      always_comb begin
        st_nxt[i] = st_in[i];
        if ({2'b00, st_in[i].rem_e} >= trial_e) begin
          st_nxt[i].rem_e = st_in[i].rem_e - trial_e[RAD_W-1:0];
          st_nxt[i].q_e   = st_in[i].q_e | (ROOT_W'(1) << K);
        end
        if ({2'b00, st_in[i].rem_r} >= trial_r) begin
          st_nxt[i].rem_r = st_in[i].rem_r - trial_r[RAD_W-1:0];
          st_nxt[i].q_r   = st_in[i].q_r | (ROOT_W'(1) << K);
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          st_r[i].vld <= 1'b0;
        end else begin
          st_r[i].vld <= st_nxt[i].vld;
        end
      end

      always_ff @(posedge clk) begin
        st_r[i].rem_e <= st_nxt[i].rem_e;
        st_r[i].q_e   <= st_nxt[i].q_e;
        st_r[i].rem_r <= st_nxt[i].rem_r;
        st_r[i].q_r   <= st_nxt[i].q_r;
        st_r[i].side  <= st_nxt[i].side;
      end
    end
  endgenerate

  always_comb begin
    root_o.vld   = st_r[ROOT_W-1].vld;
    root_o.h_ext = st_r[ROOT_W-1].q_e;
    root_o.h_row = st_r[ROOT_W-1].q_r;
    root_o.side  = st_r[ROOT_W-1].side;
  end

endmodule

// ===== sv/cws_finish.sv =====
module cws_finish (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cws_pkg::cws_root_t           root_i,
  output logic                         out_valid,
  output logic                         out_in_span,
  output logic [cws_pkg::ROWO_W-1:0]   out_top_row,
  output logic [cws_pkg::ROWO_W-1:0]   out_bottom_row,
  output logic [cws_pkg::COL_W-1:0]    out_left_col,
  output logic [cws_pkg::COL_W-1:0]    out_right_col
);
  import cws_pkg::*;

  function automatic logic signed [POS_W-1:0] cws_clamp(input logic signed [POS_W-1:0] v,
                                                        input logic signed [POS_W-1:0] hi);
    logic signed [POS_W-1:0] res;
    res = v;
    if (v < 0) begin
      res = '0;
    end else if (v > hi) begin
      res = hi;
    end
    return res;
  endfunction

  logic signed [POS_W-1:0] h_e_s, h_r_s;
  logic signed [POS_W-1:0] a_top_nxt, a_bot_nxt, a_left_nxt, a_right_nxt;
  logic                    a_vld_r;
  logic signed [POS_W-1:0] a_top_r, a_bot_r, a_left_r, a_right_r;
  logic [ROW_W-1:0]        a_row_r;

  logic signed [POS_W-1:0] ct, cb, cl, cr, cb_up;
  logic                    b_vld_r;
  logic [ROWO_W-1:0]       b_top_r, b_bot_r;
  logic [COL_W-1:0]        b_left_r, b_right_r;
  logic [ROW_W-1:0]        b_row_r;

  logic                    span_nxt;
  logic                    out_valid_r, out_in_span_r;
  logic [ROWO_W-1:0]       out_top_row_r, out_bottom_row_r;
  logic [COL_W-1:0]        out_left_col_r, out_right_col_r;

  // stage A: unclipped extent and row edges
  assign h_e_s = signed'({{(POS_W-ROOT_W){1'b0}}, root_i.h_ext});
  assign h_r_s = signed'({{(POS_W-ROOT_W){1'b0}}, root_i.h_row});

  assign a_top_nxt   = root_i.side.ext_mode ? root_i.side.cr - h_e_s : root_i.side.ty;
  assign a_bot_nxt   = root_i.side.ext_mode ? root_i.side.cr + h_e_s : root_i.side.ty2r;
  assign a_left_nxt  = root_i.side.cx - h_r_s;
  assign a_right_nxt = root_i.side.cx + h_r_s;

  always_ff @(posedge clk) begin
    a_top_r   <= a_top_nxt;
    a_bot_r   <= a_bot_nxt;
    a_left_r  <= a_left_nxt;
    a_right_r <= a_right_nxt;
    a_row_r   <= root_i.side.row;
  end

  // stage B: clip to screen, whole rows and columns
  assign ct    = cws_clamp(a_top_r, SCR_H_FP);
  assign cb    = cws_clamp(a_bot_r, SCR_H_FP);
  assign cl    = cws_clamp(a_left_r, SCR_W_FP);
  assign cr    = cws_clamp(a_right_r, SCR_W_FP);
  assign cb_up = cb + ONE_M1;

  always_ff @(posedge clk) begin
    b_top_r   <= ct[FRAC_BITS +: ROWO_W];
    b_bot_r   <= cb_up[FRAC_BITS +: ROWO_W];
    b_left_r  <= cl[FRAC_BITS +: COL_W];
    b_right_r <= cr[FRAC_BITS +: COL_W];
    b_row_r   <= a_row_r;
  end

  // stage C: span test, output register
  assign span_nxt = (b_row_r >= b_top_r) && (b_row_r < b_bot_r);

  always_ff @(posedge clk) begin
    out_in_span_r    <= span_nxt;
    out_top_row_r    <= b_top_r;
    out_bottom_row_r <= b_bot_r;
    out_left_col_r   <= span_nxt ? b_left_r : '0;
    out_right_col_r  <= span_nxt ? b_right_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_vld_r     <= root_i.vld;
      b_vld_r     <= a_vld_r;
      out_valid_r <= b_vld_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_in_span    = out_in_span_r;
  assign out_top_row    = out_top_row_r;
  assign out_bottom_row = out_bottom_row_r;
  assign out_left_col   = out_left_col_r;
  assign out_right_col  = out_right_col_r;

endmodule

// ===== sv/circle_window_span_core.sv =====
// Channel   Ports                                   Transfer
// -------   -------------------------------------   ------------------------------
// input     start, busy, in_center_x, in_top_y,     edge with start high, busy low
//           in_hole_radius, in_row
// result    out_valid, out_in_span, out_top_row,    edge ending the out_valid cycle
//           out_bottom_row, out_left_col,
//           out_right_col
//
// One item per cycle sustained; each result passes through 3 prep stages, one stage
// per root bit over 20 bits and 3 finishing stages after its start transfer.
// The digit-by-digit square root sets the depth.
// Synchronous active-low reset empties the pipe; busy is high during reset and
// drops the cycle after. Results are never held back, so busy stays low there.
module circle_window_span_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [cws_pkg::CX_W-1:0]    in_center_x,
  input  logic signed [cws_pkg::TY_W-1:0]    in_top_y,
  input  logic [cws_pkg::R_W-1:0]            in_hole_radius,
  input  logic [cws_pkg::ROW_W-1:0]          in_row,
  output logic                               out_valid,
  output logic                               out_in_span,
  output logic [cws_pkg::ROWO_W-1:0]         out_top_row,
  output logic [cws_pkg::ROWO_W-1:0]         out_bottom_row,
  output logic [cws_pkg::COL_W-1:0]          out_left_col,
  output logic [cws_pkg::COL_W-1:0]          out_right_col
);
  import cws_pkg::*;

  logic      busy_r;
  logic      in_vld;
  cws_rad_t  rad;
  cws_root_t root;

  // only held off while in reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign in_vld = start & ~busy_r;

  // clamp radius, centre distances, squares, radicands
  cws_prep u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (in_vld),
    .in_cx  (in_center_x),
    .in_ty  (in_top_y),
    .in_r   (in_hole_radius),
    .in_row (in_row),
    .rad_o  (rad)
  );

  // two half chords: screen-edge chord and this row's chord
  cws_root_pipe u_root (
    .clk    (clk),
    .rst_n  (rst_n),
    .rad_i  (rad),
    .root_o (root)
  );

  // extent, edges, clipping, span test
  cws_finish u_fin (
    .clk            (clk),
    .rst_n          (rst_n),
    .root_i         (root),
    .out_valid      (out_valid),
    .out_in_span    (out_in_span),
    .out_top_row    (out_top_row),
    .out_bottom_row (out_bottom_row),
    .out_left_col   (out_left_col),
    .out_right_col  (out_right_col)
  );

endmodule

// ===== sv/cws_checker.sv =====
module cws_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_valid,
  input logic                               out_in_span,
  input logic [cws_pkg::ROWO_W-1:0]         out_top_row,
  input logic [cws_pkg::ROWO_W-1:0]         out_bottom_row,
  input logic [cws_pkg::COL_W-1:0]          out_left_col,
  input logic [cws_pkg::COL_W-1:0]          out_right_col
);
  import cws_pkg::*;

  // every transfer gives a result
  a_lat_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("result missing after transfer");

  // no result without a transfer
  a_lat_none: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##PIPE_LAT !out_valid)
    else $error("result without transfer");

  // a row inside the span implies a non-empty span
  a_span_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_in_span) |-> (out_top_row < out_bottom_row))
    else $error("span flagged with empty row range");

  // columns are zero off the span and ordered on it
  a_cols: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_in_span ? (out_left_col <= out_right_col)
                               : (out_left_col == '0 && out_right_col == '0)))
    else $error("bad column pair");

endmodule

bind circle_window_span_core cws_checker u_chk (.*);
